@@ hw/rtl/multidim_tile_enumerator_top_assert.svh @@
// assertion macros for the tile enumerator checker
// depends on nothing; included by the checker file only
`ifndef MULTIDIM_TILE_ENUMERATOR_TOP_ASSERT_SVH
`define MULTIDIM_TILE_ENUMERATOR_TOP_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define MTE_ASSERT_NOW(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("tile enumerator check failed");

// next-cycle implication, disabled while reset is low
`define MTE_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("tile enumerator check failed");

`endif

@@ hw/rtl/mte_pkg.sv @@
// shared constants and types of the tile enumerator
// no dependencies; compiled first
package mte_pkg;

	localparam int DIMS_DEF       = 4;
	localparam int COORD_BITS_DEF = 16;
	localparam int DIM_W          = 3;
	localparam int ACT_W          = 4;

	localparam logic [ACT_W-1:0] ACT_RESET = 4'd1;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_STEP = 1'b1;

	// memory strobes from the walker to the store
	typedef struct packed {
		logic ld_we;
		logic cur_we;
		logic rd_en;
	} mte_mem_ctl_t;

endpackage

@@ hw/rtl/mte_if.sv @@
// request and result channels of the tile enumerator
// depends on mte_pkg
interface mte_req_if #(
	parameter int COORD_BITS = mte_pkg::COORD_BITS_DEF
);
	logic                        valid;
	logic                        ready;
	logic                        req_type;
	logic [mte_pkg::DIM_W-1:0]   dim_index;
	logic [COORD_BITS-1:0]       outer_low;
	logic [COORD_BITS-1:0]       outer_high;
	logic [COORD_BITS:0]         tile_size;

	modport source (
		output valid, req_type, dim_index, outer_low, outer_high, tile_size,
		input  ready
	);
	modport sink (
		input  valid, req_type, dim_index, outer_low, outer_high, tile_size,
		output ready
	);
endinterface

interface mte_res_if #(
	parameter int COORD_BITS = mte_pkg::COORD_BITS_DEF
);
	logic                        valid;
	logic                        ready;
	logic [mte_pkg::DIM_W-1:0]   out_dim;
	logic [COORD_BITS-1:0]       tile_low;
	logic [COORD_BITS-1:0]       tile_high;
	logic                        last_dim;
	logic                        last_tile;

	modport source (
		output valid, out_dim, tile_low, tile_high, last_dim, last_tile,
		input  ready
	);
	modport sink (
		input  valid, out_dim, tile_low, tile_high, last_dim, last_tile,
		output ready
	);
endinterface

@@ hw/rtl/multidim_tile_enumerator_top.sv @@
// top level of the tile enumerator: active-dimension register, walker and store
// depends on mte_pkg, mte_if, mte_store and mte_walk
//
// A load item writes one dimension's bounds and tile size and parks its cursor at
// the low bound as it is taken. A step item gives one result per active
// dimension (active_dims held to 1..DIMS), dimension 0 first: the single read port
// of the bound and cursor memories visits one dimension entry per cycle while the
// result side keeps up, and the odometer carry rides along that walk. When the
// carry reaches the last active dimension (always so with one dimension) that
// dimension's end flag is refreshed before the next item is taken. The last result
// of a step can wait in the output register while the next item is taken.
module multidim_tile_enumerator_top #(
	parameter int DIMS       = mte_pkg::DIMS_DEF,
	parameter int COORD_BITS = mte_pkg::COORD_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [mte_pkg::ACT_W-1:0]   cfg_wdata,
	mte_req_if.sink                     req,
	mte_res_if.source                   res
);
	import mte_pkg::*;

	localparam int AW = (DIMS > 1) ? $clog2(DIMS) : 1;

	logic [ACT_W-1:0]      active_dims_q;
	mte_mem_ctl_t          ctl;
	logic [AW-1:0]         ld_addr;
	logic [COORD_BITS-1:0] ld_low;
	logic [COORD_BITS-1:0] ld_high;
	logic [COORD_BITS:0]   ld_edge;
	logic [AW-1:0]         cur_addr;
	logic [COORD_BITS-1:0] cur_data;
	logic [AW-1:0]         rd_addr;
	logic [COORD_BITS-1:0] rd_low;
	logic [COORD_BITS-1:0] rd_high;
	logic [COORD_BITS:0]   rd_edge;
	logic [COORD_BITS-1:0] rd_cur;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_dims_q <= ACT_RESET;
		end else if (cfg_we) begin
			active_dims_q <= cfg_wdata;
		end
	end

	mte_walk #(
		.DIMS       (DIMS),
		.COORD_BITS (COORD_BITS)
	) u_walk (
		.clk         (clk),
		.arst_n      (arst_n),
		.active_dims (active_dims_q),
		.req         (req),
		.res         (res),
		.ctl         (ctl),
		.ld_addr     (ld_addr),
		.ld_low      (ld_low),
		.ld_high     (ld_high),
		.ld_edge     (ld_edge),
		.cur_addr    (cur_addr),
		.cur_data    (cur_data),
		.rd_addr     (rd_addr),
		.rd_low      (rd_low),
		.rd_high     (rd_high),
		.rd_edge     (rd_edge),
		.rd_cur      (rd_cur)
	);

	mte_store #(
		.DIMS       (DIMS),
		.COORD_BITS (COORD_BITS)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.ld_addr  (ld_addr),
		.ld_low   (ld_low),
		.ld_high  (ld_high),
		.ld_edge  (ld_edge),
		.cur_addr (cur_addr),
		.cur_data (cur_data),
		.rd_addr  (rd_addr),
		.rd_low   (rd_low),
		.rd_high  (rd_high),
		.rd_edge  (rd_edge),
		.rd_cur   (rd_cur)
	);

endmodule

@@ hw/rtl/mte_store.sv @@
// bound memory and cursor memory, one read port each with registered data
// depends on mte_pkg
module mte_store #(
	parameter int DIMS       = mte_pkg::DIMS_DEF,
	parameter int COORD_BITS = mte_pkg::COORD_BITS_DEF,
	localparam int AW        = (DIMS > 1) ? $clog2(DIMS) : 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  mte_pkg::mte_mem_ctl_t     ctl,
	input  logic [AW-1:0]             ld_addr,
	input  logic [COORD_BITS-1:0]     ld_low,
	input  logic [COORD_BITS-1:0]     ld_high,
	input  logic [COORD_BITS:0]       ld_edge,
	input  logic [AW-1:0]             cur_addr,
	input  logic [COORD_BITS-1:0]     cur_data,
	input  logic [AW-1:0]             rd_addr,
	output logic [COORD_BITS-1:0]     rd_low,
	output logic [COORD_BITS-1:0]     rd_high,
	output logic [COORD_BITS:0]       rd_edge,
	output logic [COORD_BITS-1:0]     rd_cur
);
	import mte_pkg::*;

	localparam int BW = 3 * COORD_BITS + 1;

	logic [BW-1:0]         bnd_mem [DIMS];
	logic [COORD_BITS-1:0] cur_mem [DIMS];
	logic [BW-1:0]         bnd_rd_q;
	logic [COORD_BITS-1:0] cur_rd_q;
	logic [DIMS-1:0]       cur_ok_q;
	logic                  cur_rd_ok_q;

	always_ff @(posedge clk) begin
		if (ctl.ld_we) begin
			bnd_mem[ld_addr] <= {ld_low, ld_high, ld_edge};
		end
		if (ctl.cur_we) begin
			cur_mem[cur_addr] <= cur_data;
		end
		if (ctl.rd_en) begin
			bnd_rd_q <= bnd_mem[rd_addr];
			cur_rd_q <= cur_mem[rd_addr];
		end
	end

	// cursors come out of reset at zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_ok_q    <= '0;
			cur_rd_ok_q <= 1'b0;
		end else begin
			if (ctl.cur_we) begin
				cur_ok_q[cur_addr] <= 1'b1;
			end
			if (ctl.rd_en) begin
				cur_rd_ok_q <= cur_ok_q[rd_addr];
			end
		end
	end

	assign rd_low  = bnd_rd_q[BW-1 -: COORD_BITS];
	assign rd_high = bnd_rd_q[COORD_BITS+1 +: COORD_BITS];
	assign rd_edge = bnd_rd_q[COORD_BITS:0];
	assign rd_cur  = cur_rd_ok_q ? cur_rd_q : '0;

endmodule

@@ hw/rtl/mte_walk.sv @@
// request handling, dimension sequencer, odometer update and result register
// depends on mte_pkg and mte_if; drives the memories in mte_store
module mte_walk #(
	parameter int DIMS       = mte_pkg::DIMS_DEF,
	parameter int COORD_BITS = mte_pkg::COORD_BITS_DEF,
	localparam int AW        = (DIMS > 1) ? $clog2(DIMS) : 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [mte_pkg::ACT_W-1:0]   active_dims,
	mte_req_if.sink                     req,
	mte_res_if.source                   res,
	output mte_pkg::mte_mem_ctl_t       ctl,
	output logic [AW-1:0]               ld_addr,
	output logic [COORD_BITS-1:0]       ld_low,
	output logic [COORD_BITS-1:0]       ld_high,
	output logic [COORD_BITS:0]         ld_edge,
	output logic [AW-1:0]               cur_addr,
	output logic [COORD_BITS-1:0]       cur_data,
	output logic [AW-1:0]               rd_addr,
	input  logic [COORD_BITS-1:0]       rd_low,
	input  logic [COORD_BITS-1:0]       rd_high,
	input  logic [COORD_BITS:0]         rd_edge,
	input  logic [COORD_BITS-1:0]       rd_cur
);
	import mte_pkg::*;

	localparam int SW = COORD_BITS + 2;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic                  state_q;
	logic [ACT_W-1:0]      n_q;
	logic [ACT_W-1:0]      rd_idx_q;
	logic                  last_q;
	logic                  carry_q;
	logic                  s1_valid_q;
	logic [AW-1:0]         s1_dim_q;
	logic [DIMS-1:0]       at_end_q;

	logic                  upd_valid_s2;
	logic [AW-1:0]         upd_dim_s2;
	logic [COORD_BITS-1:0] upd_cur_s2;
	logic [COORD_BITS:0]   upd_edge_s2;
	logic [COORD_BITS-1:0] upd_high_s2;

	logic                  out_valid_q;
	logic [DIM_W-1:0]      out_dim_q;
	logic [COORD_BITS-1:0] tile_low_q;
	logic [COORD_BITS-1:0] tile_high_q;
	logic                  last_dim_q;
	logic                  last_tile_q;

	logic [ACT_W-1:0]      n_use;
	logic [DIMS-1:0]       act_mask;
	logic                  tile_last;
	logic                  acc;
	logic                  acc_ld;
	logic                  acc_st;
	logic                  dim_ok;
	logic                  ld_end;
	logic                  adv;
	logic                  issue_run;
	logic                  s1_last;
	logic [SW-1:0]         sum;
	logic [SW-1:0]         top_raw;
	logic                  fits;
	logic [COORD_BITS-1:0] top;
	logic [COORD_BITS-1:0] new_cur;
	logic                  upd_end;

	// active count saturated into 1..DIMS
	always_comb begin
		if (active_dims == '0) begin
			n_use = ACT_W'(1);
		end else if (active_dims > ACT_W'(DIMS)) begin
			n_use = ACT_W'(DIMS);
		end else begin
			n_use = active_dims;
		end
		for (int d = 0; d < DIMS; d++) begin
			act_mask[d] = ACT_W'(d) < n_use;
		end
	end

	// final tile when no active dimension can still advance
	assign tile_last = &(at_end_q | ~act_mask);

	assign req.ready = (state_q == ST_IDLE) && !upd_valid_s2;
	assign acc       = req.valid && req.ready;
	assign dim_ok    = {1'b0, req.dim_index} < ACT_W'(DIMS);
	assign acc_ld    = acc && (req.req_type == REQ_LOAD) && dim_ok;
	assign acc_st    = acc && (req.req_type == REQ_STEP);

	assign ld_addr = req.dim_index[AW-1:0];
	assign ld_low  = req.outer_low;
	assign ld_high = (req.outer_high < req.outer_low) ? req.outer_low : req.outer_high;
	assign ld_edge = (req.tile_size == '0) ? (COORD_BITS+1)'(1) : req.tile_size;
	assign ld_end  = ({2'b00, ld_low} + {1'b0, ld_edge}) > {2'b00, ld_high};

	assign adv       = s1_valid_q && (!out_valid_q || res.ready);
	assign issue_run = (state_q == ST_RUN) && (rd_idx_q < n_q) && (!s1_valid_q || adv);
	assign rd_addr   = acc_st ? '0 : rd_idx_q[AW-1:0];
	assign s1_last   = (ACT_W'(s1_dim_q) + ACT_W'(1)) == n_q;

	// row of the dimension in stage one
	assign sum     = {2'b00, rd_cur} + {1'b0, rd_edge};
	assign top_raw = sum - SW'(1);
	assign fits    = sum <= {2'b00, rd_high};
	assign top     = (top_raw > {2'b00, rd_high}) ? rd_high : top_raw[COORD_BITS-1:0];
	assign new_cur = fits ? sum[COORD_BITS-1:0] : rd_low;

	assign upd_end = ({2'b00, upd_cur_s2} + {1'b0, upd_edge_s2}) > {2'b00, upd_high_s2};

	// loads and cursor updates never coincide: loads are taken only when idle
	assign ctl.ld_we  = acc_ld;
	assign ctl.cur_we = acc_ld || (adv && carry_q);
	assign ctl.rd_en  = acc_st || issue_run;
	assign cur_addr   = acc_ld ? req.dim_index[AW-1:0] : s1_dim_q;
	assign cur_data   = acc_ld ? req.outer_low : new_cur;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			n_q          <= ACT_RESET;
			rd_idx_q     <= '0;
			last_q       <= 1'b0;
			carry_q      <= 1'b0;
			s1_valid_q   <= 1'b0;
			at_end_q     <= '1;
			upd_valid_s2 <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (acc_st) begin
						state_q  <= ST_RUN;
						n_q      <= n_use;
						rd_idx_q <= ACT_W'(1);
						last_q   <= tile_last;
						carry_q  <= 1'b1;
					end
				end
				ST_RUN: begin
					if (issue_run) begin
						rd_idx_q <= rd_idx_q + ACT_W'(1);
					end
					if (adv && carry_q && fits) begin
						carry_q <= 1'b0;
					end
					if (adv && s1_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (ctl.rd_en) begin
				s1_valid_q <= 1'b1;
			end else if (adv) begin
				s1_valid_q <= 1'b0;
			end

			upd_valid_s2 <= adv && carry_q;

			if (acc_ld) begin
				at_end_q[ld_addr] <= ld_end;
			end
			if (upd_valid_s2) begin
				at_end_q[upd_dim_s2] <= upd_end;
			end

			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			s1_dim_q <= rd_addr;
		end
		if (adv) begin
			upd_dim_s2  <= s1_dim_q;
			upd_cur_s2  <= new_cur;
			upd_edge_s2 <= rd_edge;
			upd_high_s2 <= rd_high;
			out_dim_q   <= DIM_W'(s1_dim_q);
			tile_low_q  <= rd_cur;
			tile_high_q <= top;
			last_dim_q  <= s1_last;
			last_tile_q <= last_q;
		end
	end

	assign res.valid     = out_valid_q;
	assign res.out_dim   = out_dim_q;
	assign res.tile_low  = tile_low_q;
	assign res.tile_high = tile_high_q;
	assign res.last_dim  = last_dim_q;
	assign res.last_tile = last_tile_q;

endmodule

@@ hw/rtl/mte_chk.sv @@
// port-level checker for the tile enumerator, bound to the top level
// depends on mte_pkg and the assertion macro header
`include "multidim_tile_enumerator_top_assert.svh"

module mte_chk (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       req_valid,
	input logic                       req_ready,
	input logic                       req_type,
	input logic                       res_valid,
	input logic                       res_ready,
	input logic                       res_last_dim,
	input logic                       res_last_tile
);
	import mte_pkg::*;

	// a shown result stays until taken
	`MTE_ASSERT_NXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid)

	// a load item never produces a result
	`MTE_ASSERT_NXT(a_load_quiet, clk, arst_n, req_valid && req_ready && (req_type == REQ_LOAD) && !res_valid, !res_valid)

	// rows of one tile follow without gaps and share the final-tile flag
	`MTE_ASSERT_NXT(a_run_dense, clk, arst_n, res_valid && res_ready && !res_last_dim, res_valid && (res_last_tile == $past(res_last_tile)))

	// no item is taken while a tile run is still open
	`MTE_ASSERT_NOW(a_run_busy, clk, arst_n, res_valid && !res_last_dim, !req_ready)

endmodule

bind multidim_tile_enumerator_top mte_chk u_mte_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.req_type      (req.req_type),
	.res_valid     (res.valid),
	.res_ready     (res.ready),
	.res_last_dim  (res.last_dim),
	.res_last_tile (res.last_tile)
);

@@ tb/tb_multidim_tile_enumerator_top.sv @@
// self-checking testbench for multidim_tile_enumerator_top: predicts every tile row
// from its own copy of the box bounds and cursors; needs mte_pkg, mte_if and the rtl
module tb_multidim_tile_enumerator_top;
	import mte_pkg::*;

	localparam int DIMS       = 4;
	localparam int CB         = 16;
	localparam int TS_W       = CB + 1;
	localparam int SETTLE     = 16;
	localparam int RAND_ITEMS = 430;
	localparam int LIMIT_TIME = 3_000_000;

	typedef struct {
		logic              req_type;
		logic [DIM_W-1:0]  dim;
		logic [CB-1:0]     lo;
		logic [CB-1:0]     hi;
		logic [TS_W-1:0]   ts;
	} tile_req_t;

	typedef struct {
		logic [DIM_W-1:0]  dim;
		logic [CB-1:0]     lo;
		logic [CB-1:0]     hi;
		logic              last_dim;
		logic              last_tile;
	} tile_row_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [ACT_W-1:0] cfg_wdata;

	mte_req_if #(.COORD_BITS(CB)) req_ch ();
	mte_res_if #(.COORD_BITS(CB)) res_ch ();

	multidim_tile_enumerator_top #(
		.DIMS       (DIMS),
		.COORD_BITS (CB)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.res       (res_ch)
	);

	// predicted block state
	logic [ACT_W-1:0] act_cfg;
	logic [CB-1:0]    box_lo   [DIMS];
	logic [CB-1:0]    box_hi   [DIMS];
	logic [TS_W-1:0]  box_edge [DIMS];
	logic [CB-1:0]    box_cur  [DIMS];

	tile_req_t pending_q [$];
	tile_row_t tile_rows_q [$];
	tile_req_t cur_req;

	int pushed_cnt, taken_cnt, load_cnt, step_cnt, rows_ok, bad_cnt, cfg_cnt;
	int send_wait, recv_wait;
	bit quiet;
	bit req_taken;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic int dims_used();
		if (act_cfg == 0)
			return 1;
		if (act_cfg > DIMS)
			return DIMS;
		return int'(act_cfg);
	endfunction

	function automatic void predict_request(tile_req_t r);
		int        n;
		bit        final_tile;
		longint    c, e, h, top;
		tile_row_t row;
		if (r.req_type == REQ_LOAD) begin
			if (r.dim < DIMS) begin
				box_lo[r.dim]   = r.lo;
				box_hi[r.dim]   = (r.hi < r.lo) ? r.lo : r.hi;
				box_edge[r.dim] = (r.ts == 0) ? TS_W'(1) : r.ts;
				box_cur[r.dim]  = r.lo;
			end
			return;
		end
		n = dims_used();
		final_tile = 1'b1;
		for (int d = 0; d < n; d++) begin
			c = box_cur[d];
			e = box_edge[d];
			h = box_hi[d];
			if (c + e <= h)
				final_tile = 1'b0;
		end
		for (int d = 0; d < n; d++) begin
			c = box_cur[d];
			e = box_edge[d];
			h = box_hi[d];
			top = c + e - 1;
			if (top > h)
				top = h;
			row.dim       = DIM_W'(d);
			row.lo        = box_cur[d];
			row.hi        = top[CB-1:0];
			row.last_dim  = (d == n - 1);
			row.last_tile = final_tile;
			tile_rows_q.insert(tile_rows_q.size(), row);
		end
		// odometer: first dimension that can still advance takes the step
		for (int d = 0; d < n; d++) begin
			c = box_cur[d];
			e = box_edge[d];
			h = box_hi[d];
			if (c + e <= h) begin
				box_cur[d] = CB'(c + e);
				break;
			end
			box_cur[d] = box_lo[d];
		end
	endfunction

	task automatic queue_load(input int dim, input logic [CB-1:0] lo, input logic [CB-1:0] hi,
			input logic [TS_W-1:0] ts);
		tile_req_t r;
		r.req_type = REQ_LOAD;
		r.dim      = DIM_W'(dim);
		r.lo       = lo;
		r.hi       = hi;
		r.ts       = ts;
		pending_q.insert(pending_q.size(), r);
		pushed_cnt++;
		load_cnt++;
	endtask

	task automatic queue_step();
		tile_req_t r;
		r.req_type = REQ_STEP;
		r.dim      = DIM_W'($urandom);
		r.lo       = CB'($urandom);
		r.hi       = CB'($urandom);
		r.ts       = TS_W'($urandom);
		pending_q.insert(pending_q.size(), r);
		pushed_cnt++;
		step_cnt++;
	endtask

	// small box so the walk wraps and the last tile comes around often
	task automatic queue_small_box(input int dim, input int span_max);
		int lo, span, hi;
		lo   = $urandom_range(0, 65535);
		span = $urandom_range(0, span_max);
		hi   = (lo + span > 65535) ? 65535 : lo + span;
		queue_load(dim, CB'(lo), CB'(hi), TS_W'($urandom_range(1, 12)));
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (taken_cnt != pushed_cnt || tile_rows_q.size() != 0);
		// loads leave no row behind, give the walker time to finish
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_cfg(input int value);
		cfg_we    <= 1'b1;
		cfg_wdata <= ACT_W'(value);
		@(negedge clk);
		cfg_we  <= 1'b0;
		act_cfg = ACT_W'(value);
		cfg_cnt++;
	endtask

	// request driver
	always @(negedge clk) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else if (req_ch.valid && !req_taken) begin
			// hold the item until it is taken
		end else if (send_wait > 0) begin
			req_ch.valid <= 1'b0;
			send_wait--;
		end else if (pending_q.size() != 0) begin
			cur_req = pending_q.pop_front();
			req_ch.valid      <= 1'b1;
			req_ch.req_type   <= cur_req.req_type;
			req_ch.dim_index  <= cur_req.dim;
			req_ch.outer_low  <= cur_req.lo;
			req_ch.outer_high <= cur_req.hi;
			req_ch.tile_size  <= cur_req.ts;
			send_wait = quiet ? 0 : $urandom_range(0, 8);
		end else begin
			req_ch.valid <= 1'b0;
		end
	end

	// result back-pressure
	always @(negedge clk) begin
		if (recv_wait > 0) begin
			res_ch.ready <= 1'b0;
			recv_wait--;
		end else begin
			res_ch.ready <= 1'b1;
		end
	end

	// acceptance and result check
	always @(posedge clk) begin
		tile_row_t want;
		bit        ok;
		req_taken = arst_n && req_ch.valid && req_ch.ready;
		if (req_taken) begin
			predict_request(cur_req);
			taken_cnt++;
		end
		if (arst_n && res_ch.valid && res_ch.ready) begin
			recv_wait = quiet ? 0 : $urandom_range(0, 8);
			if (tile_rows_q.size() == 0) begin
				bad_cnt++;
				if (bad_cnt <= 10)
					$display("unexpected tile row: dim %0d low %0h high %0h last_dim %0b last_tile %0b",
						res_ch.out_dim, res_ch.tile_low, res_ch.tile_high,
						res_ch.last_dim, res_ch.last_tile);
			end else begin
				want = tile_rows_q.pop_front();
				ok = (res_ch.out_dim === want.dim) && (res_ch.tile_low === want.lo) &&
					(res_ch.tile_high === want.hi) && (res_ch.last_dim === want.last_dim) &&
					(res_ch.last_tile === want.last_tile);
				if (ok) begin
					rows_ok++;
				end else begin
					bad_cnt++;
					if (bad_cnt <= 10) begin
						$display("tile row mismatch at %0t", $realtime);
						$display("  expected dim %0d low %0h high %0h last_dim %0b last_tile %0b",
							want.dim, want.lo, want.hi, want.last_dim, want.last_tile);
						$display("  got      dim %0d low %0h high %0h last_dim %0b last_tile %0b",
							res_ch.out_dim, res_ch.tile_low, res_ch.tile_high,
							res_ch.last_dim, res_ch.last_tile);
					end
				end
			end
		end
	end

	initial begin
		#(LIMIT_TIME);
		$display("timeout with %0d tile rows still expected", tile_rows_q.size());
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		int act_list [6];
		int made, n_use, span_max, seg, k, dim;
		act_list = '{1, 2, 3, 4, 0, 15};
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_wdata         = '0;
		req_ch.valid      = 1'b0;
		req_ch.req_type   = REQ_LOAD;
		req_ch.dim_index  = '0;
		req_ch.outer_low  = '0;
		req_ch.outer_high = '0;
		req_ch.tile_size  = '0;
		res_ch.ready      = 1'b0;
		act_cfg           = ACT_RESET;
		quiet             = 1'b0;
		for (int d = 0; d < DIMS; d++) begin
			box_lo[d]   = '0;
			box_hi[d]   = '0;
			box_edge[d] = '0;
			box_cur[d]  = '0;
		end
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// directed: full-range tile, inverted bounds, zero and huge tile sizes,
		// loads to dimensions that are not built, clipping of the last tile
		queue_load(0, 16'h0000, 16'hFFFF, 17'h10000);
		queue_step();
		queue_step();
		queue_load(1, 16'hFFFF, 16'h0000, 17'h00000);
		queue_load(2, 16'd100, 16'd109, 17'd3);
		queue_load(3, 16'hAAAA, 16'h5555, 17'h1FFFF);
		queue_load(5, 16'h5555, 16'hAAAA, 17'h0AAAA);
		queue_load(7, 16'hFFFF, 16'hFFFF, 17'h1FFFF);
		queue_load(4, 16'h0000, 16'h0000, 17'h00000);
		queue_load(0, 16'd5, 16'd14, 17'd4);
		repeat (4) queue_step();
		wait_drained();
		write_cfg(4);
		@(posedge clk);
		repeat (6) queue_step();
		wait_drained();
		write_cfg(15);
		@(posedge clk);
		repeat (3) queue_step();
		wait_drained();
		write_cfg(0);
		@(posedge clk);
		repeat (2) queue_step();

		// random phases, each under its own dimension count
		made = 0;
		for (int ph = 0; made < RAND_ITEMS; ph++) begin
			wait_drained();
			write_cfg(ph < 6 ? act_list[ph] : $urandom_range(0, 15));
			quiet    = (ph % 4 == 2);
			n_use    = dims_used();
			span_max = (n_use <= 2) ? 40 : 8;
			@(posedge clk);
			for (int d = 0; d < n_use; d++) begin
				if ($urandom_range(0, 3) != 0) begin
					queue_small_box(d, span_max);
					made++;
				end
			end
			seg = $urandom_range(25, 45);
			repeat (seg) begin
				k = $urandom_range(0, 99);
				if (k < 70) begin
					queue_step();
					made++;
				end else if (k < 88) begin
					queue_small_box($urandom_range(0, DIMS - 1), span_max);
					made++;
				end else begin
					// noise: any bounds, any tile size, any dimension
					dim = $urandom_range(0, 7);
					queue_load(dim, CB'($urandom), CB'($urandom), TS_W'($urandom));
					if (dim < DIMS)
						made++;
				end
			end
		end

		wait_drained();
		$display("covered %0d load items and %0d step items over %0d register settings",
			load_cnt, step_cnt, cfg_cnt);
		$display("%0d tile rows matched, %0d bad", rows_ok, bad_cnt);
		if (bad_cnt == 0 && tile_rows_q.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
